### src/circ_pkg.sv
// Shared types and codes for the chunk index range coalescer.
package circ_pkg;

	localparam int IDX_W = 32;
	localparam int CB_W = 32;
	localparam int SZ_W = 48;
	localparam int ST_W = 3;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_CHUNK_BYTES = 1'b0;
	localparam cfg_idx_t CFG_TOT_BYTES = 1'b1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	typedef logic [ST_W-1:0] status_t;
	localparam status_t STAT_OK = 3'd0;
	localparam status_t STAT_PAST_END = 3'd1;
	localparam status_t STAT_DROPPED = 3'd2;
	localparam status_t STAT_TRUNC = 3'd3;
	localparam status_t STAT_EMPTY = 3'd4;

	localparam logic [SZ_W-1:0] SZ_MAX = {SZ_W{1'b1}};

	typedef enum logic [3:0] {
		S_IDLE,
		S_L_RD,
		S_L_CMP,
		S_L_DEC,
		S_L_SH,
		S_L_SHW,
		S_E_RD,
		S_E_CMP,
		S_E_MUL1,
		S_E_MUL2,
		S_E_OUT,
		S_S_CHK,
		S_S_OUT
	} state_t;

endpackage

### src/circ_req_if.sv
// Request channel: command and chunk index.
interface circ_req_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [31:0] chunk_index;

	modport source(output valid, output cmd, output chunk_index, input ready);
	modport sink(input valid, input cmd, input chunk_index, output ready);
endinterface

### src/circ_rsp_if.sv
// Result channel: one byte range per transfer.
interface circ_rsp_if;
	logic valid;
	logic ready;
	logic [47:0] range_offset;
	logic [47:0] range_length;
	logic last_range;
	logic [2:0] status;

	modport source(output valid, output range_offset, output range_length,
		output last_range, output status, input ready);
	modport sink(input valid, input range_offset, input range_length,
		input last_range, input status, output ready);
endinterface

### src/chunk_index_range_coalescer_core.sv
// Chunk index range coalescer: sorted index store in RAM, range emission.
//
// Channels: req carries cmd and chunk_index; cmd 0 loads an index into a
// sorted, duplicate-free store, cmd 1 emits byte ranges and clears the store.
// rsp carries one range per transfer (offset, length, last_range, status).
// Configuration: cfg_we with cfg_idx 0 writes chunk_bytes, 1 the total byte size.
// The store lives in one RAM of MAX_INDICES words with registered read.
// A load scans the store, reading and comparing each entry below the insertion
// point, then shifts the entries above it up one place, each read and then
// written. A duplicate ends at the matching entry.
// An indexed emit reads and compares each entry in turn, then runs each range
// through the shared 33x32 multiplier (start and end offsets).
// An empty-store emit splits the total into chunks (one range if total or chunk
// size is 0), one range per cycle while rsp is free, at most MAX_INDICES ranges.
// req is ready only while no request is in progress.
// Results sit in an output register; a stalled receiver holds the emit
// sequence in place without losing results.
// Reset initialises only the control registers (count, dropped flag, sizes);
// the RAM needs no clearing since only entries below the count are read.
module chunk_index_range_coalescer_core #(
	parameter int MAX_INDICES = 64
) (
	input logic clk,
	input logic arst_n,
	circ_req_if.sink req,
	circ_rsp_if.source rsp,
	input logic cfg_we,
	input circ_pkg::cfg_idx_t cfg_idx,
	input logic [circ_pkg::SZ_W-1:0] cfg_wdata
);
	import circ_pkg::*;

	localparam int AW = $clog2(MAX_INDICES);
	localparam int CW = $clog2(MAX_INDICES + 1);
	localparam logic [CW-1:0] N_MAX = CW'(MAX_INDICES);
	localparam logic [CW-1:0] K_LAST = CW'(MAX_INDICES - 1);

	state_t state_q, state_d;

	logic [CB_W-1:0] cb_q;
	logic [SZ_W-1:0] tot_q;
	logic [CW-1:0] n_q, i_q, j_q, pos_q, k_q;
	logic drop_q, lastr_q, trunc_q;
	logic [IDX_W-1:0] v_q, first_q, prev_q, hold_q;
	logic [64:0] mul_q;
	logic [63:0] moff_q;
	logic [SZ_W-1:0] soff_q;

	logic ov_q, olast_q;
	logic [SZ_W-1:0] ooff_q, olen_q;
	status_t ostat_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [IDX_W-1:0] ram_wdata, ram_rdata;

	logic ofree, acc;
	logic [32:0] mul_a;
	logic [64:0] product;
	logic [CW-1:0] ni;
	logic [CW-1:0] jm1;

	// run output
	logic past;
	logic [64:0] end_cl;
	logic [SZ_W-1:0] r_off, r_len;
	status_t r_stat;

	// split output
	logic [SZ_W-1:0] rem, s_len;
	logic [SZ_W:0] s_end;
	logic s_last;

	circ_ram #(.WIDTH(IDX_W), .DEPTH(MAX_INDICES)) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign ofree = !ov_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign acc = req.valid && req.ready;
	assign ni = i_q + CW'(1);
	assign jm1 = j_q - CW'(1);
	assign product = mul_a * {33'd0, cb_q};

	always_comb begin
		case (state_q)
			S_E_MUL1: mul_a = {1'b0, first_q};
			S_E_MUL2: mul_a = {1'b0, prev_q} + 33'd1;
			default: mul_a = 33'(MAX_INDICES);
		endcase
	end

	always_comb begin
		past = moff_q > {16'd0, tot_q};
		end_cl = (mul_q > {17'd0, tot_q}) ? {17'd0, tot_q} : mul_q;
		r_off = (moff_q > {16'd0, SZ_MAX}) ? SZ_MAX : moff_q[SZ_W-1:0];
		r_len = past ? '0 : end_cl[SZ_W-1:0] - moff_q[SZ_W-1:0];
		r_stat = past ? STAT_PAST_END : (drop_q ? STAT_DROPPED : STAT_OK);
		rem = tot_q - soff_q;
		s_len = ({16'd0, cb_q} < rem) ? {16'd0, cb_q} : rem;
		s_end = {1'b0, soff_q} + {17'd0, cb_q};
		s_last = (s_end >= {1'b0, tot_q}) || (k_q == K_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_waddr = pos_q[AW-1:0];
		ram_wdata = v_q;
		ram_raddr = i_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (req.cmd == CMD_LOAD) begin
						state_d = S_L_RD;
					end else if (n_q == '0) begin
						state_d = S_S_CHK;
					end else begin
						state_d = S_E_RD;
					end
				end
			end
			S_L_RD: begin
				state_d = (i_q == n_q) ? S_L_DEC : S_L_CMP;
			end
			S_L_CMP: begin
				if (ram_rdata < v_q) begin
					state_d = S_L_RD;
				end else if (ram_rdata == v_q) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_L_DEC;
				end
			end
			S_L_DEC: begin
				state_d = (n_q == N_MAX) ? S_IDLE : S_L_SH;
			end
			S_L_SH: begin
				if (j_q == pos_q) begin
					ram_we = 1'b1;
					state_d = S_IDLE;
				end else begin
					ram_raddr = jm1[AW-1:0];
					state_d = S_L_SHW;
				end
			end
			S_L_SHW: begin
				ram_we = 1'b1;
				ram_waddr = j_q[AW-1:0];
				ram_wdata = ram_rdata;
				state_d = S_L_SH;
			end
			S_E_RD: state_d = S_E_CMP;
			S_E_CMP: begin
				if (i_q == '0 || {1'b0, ram_rdata} == {1'b0, prev_q} + 33'd1) begin
					state_d = (ni == n_q) ? S_E_MUL1 : S_E_RD;
				end else begin
					state_d = S_E_MUL1;
				end
			end
			S_E_MUL1: state_d = S_E_MUL2;
			S_E_MUL2: state_d = S_E_OUT;
			S_E_OUT: begin
				if (ofree) begin
					if (lastr_q) begin
						state_d = S_IDLE;
					end else begin
						state_d = (ni == n_q) ? S_E_MUL1 : S_E_RD;
					end
				end
			end
			S_S_CHK: begin
				if (ofree) begin
					state_d = (tot_q == '0 || cb_q == '0) ? S_IDLE : S_S_OUT;
				end
			end
			S_S_OUT: begin
				if (ofree && s_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_q <= CB_W'(1);
			tot_q <= '0;
			n_q <= '0;
			drop_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_CHUNK_BYTES: cb_q <= cfg_wdata[CB_W-1:0];
					CFG_TOT_BYTES: tot_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_L_DEC: begin
					if (n_q == N_MAX) begin
						drop_q <= 1'b1;
					end
				end
				S_L_SH: begin
					if (j_q == pos_q) begin
						n_q <= n_q + CW'(1);
					end
				end
				S_E_OUT: begin
					if (ofree) begin
						ov_q <= 1'b1;
						if (lastr_q) begin
							n_q <= '0;
							drop_q <= 1'b0;
						end
					end
				end
				S_S_CHK: begin
					// single-result cases only; the split proper starts in S_S_OUT
					if (ofree && (tot_q == '0 || cb_q == '0)) begin
						ov_q <= 1'b1;
						drop_q <= 1'b0;
					end
				end
				S_S_OUT: begin
					if (ofree) begin
						ov_q <= 1'b1;
						if (s_last) begin
							drop_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				i_q <= '0;
				v_q <= req.chunk_index;
				mul_q <= product;
			end
			S_L_RD: begin
				if (i_q == n_q) begin
					pos_q <= n_q;
				end
			end
			S_L_CMP: begin
				if (ram_rdata < v_q) begin
					i_q <= ni;
				end else begin
					pos_q <= i_q;
				end
			end
			S_L_DEC: j_q <= n_q;
			S_L_SHW: j_q <= jm1;
			S_E_CMP: begin
				if (i_q == '0 || {1'b0, ram_rdata} == {1'b0, prev_q} + 33'd1) begin
					if (i_q == '0) begin
						first_q <= ram_rdata;
					end
					prev_q <= ram_rdata;
					i_q <= ni;
					lastr_q <= (ni == n_q);
				end else begin
					hold_q <= ram_rdata;
					lastr_q <= 1'b0;
				end
			end
			S_E_MUL1: mul_q <= product;
			S_E_MUL2: begin
				moff_q <= mul_q[63:0];
				mul_q <= product;
			end
			S_E_OUT: begin
				if (ofree) begin
					ooff_q <= r_off;
					olen_q <= r_len;
					olast_q <= lastr_q;
					ostat_q <= r_stat;
					if (!lastr_q) begin
						first_q <= hold_q;
						prev_q <= hold_q;
						i_q <= ni;
						lastr_q <= (ni == n_q);
					end
				end
			end
			S_S_CHK: begin
				if (ofree) begin
					ooff_q <= '0;
					olen_q <= tot_q;
					olast_q <= 1'b1;
					ostat_q <= (tot_q == '0) ? STAT_EMPTY : STAT_OK;
					trunc_q <= {17'd0, tot_q} > mul_q;
					soff_q <= '0;
					k_q <= '0;
				end
			end
			S_S_OUT: begin
				if (ofree) begin
					ooff_q <= soff_q;
					olen_q <= s_len;
					olast_q <= s_last;
					ostat_q <= trunc_q ? STAT_TRUNC : STAT_OK;
					soff_q <= s_end[SZ_W-1:0];
					k_q <= k_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = ov_q;
	assign rsp.range_offset = ooff_q;
	assign rsp.range_length = olen_q;
	assign rsp.last_range = olast_q;
	assign rsp.status = ostat_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= N_MAX)
		else $error("index count above store size");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_E_OUT && ofree && lastr_q) |=> (n_q == '0 && !drop_q))
		else $error("store not cleared after emit");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CW'(ram_waddr) <= n_q && n_q < N_MAX))
		else $error("store write outside filled region");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.cmd == CMD_EMIT) |=> (state_q == S_S_CHK || state_q == S_E_RD))
		else $error("emit request not started");
endmodule

### src/circ_ram.sv
// Generic single write port, single read port RAM with registered read.
module circ_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### tb/chunk_index_range_coalescer_core_tb.sv
// Testbench for chunk_index_range_coalescer_core: random index loads and emits against a range predictor.
module chunk_index_range_coalescer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import circ_pkg::*;

	localparam int MAXN = 64;
	localparam longint LIMIT = 2000000;

	typedef struct packed {
		logic [SZ_W-1:0] off;
		logic [SZ_W-1:0] len;
		logic last;
		status_t st;
	} range_t;

	class range_scoreboard;
		logic [CB_W-1:0] chunk_bytes;
		logic [SZ_W-1:0] tot_bytes;
		logic [IDX_W-1:0] store[$];
		bit dropped;
		range_t pending_ranges[$];
		int errors;

		function new();
			chunk_bytes = 1;
			tot_bytes = 0;
			dropped = 0;
			errors = 0;
		endfunction

		function void set_cfg(cfg_idx_t idx, logic [SZ_W-1:0] val);
			if (idx == CFG_CHUNK_BYTES)
				chunk_bytes = val[CB_W-1:0];
			else
				tot_bytes = val;
		endfunction

		function void add_run(logic [IDX_W-1:0] first, logic [IDX_W-1:0] lastv, bit fin);
			logic [63:0] o;
			logic [63:0] e;
			range_t r;
			o = 64'(first) * 64'(chunk_bytes);
			e = (64'(lastv) + 64'd1) * 64'(chunk_bytes);
			r.off = (o > 64'(SZ_MAX)) ? SZ_MAX : o[SZ_W-1:0];
			if (o > 64'(tot_bytes)) begin
				r.len = '0;
				r.st = STAT_PAST_END;
			end else begin
				r.len = SZ_W'(((e > 64'(tot_bytes)) ? 64'(tot_bytes) : e) - o);
				r.st = dropped ? STAT_DROPPED : STAT_OK;
			end
			r.last = fin;
			pending_ranges = {pending_ranges, r};
		endfunction

		function void note(logic cmd, logic [IDX_W-1:0] v);
			int pos;
			logic [63:0] chunks;
			logic [63:0] o;
			logic [63:0] rem;
			logic [IDX_W-1:0] first;
			logic [IDX_W-1:0] prev;
			range_t r;
			if (cmd == CMD_LOAD) begin
				pos = 0;
				while (pos < store.size() && store[pos] < v) pos++;
				if (pos < store.size() && store[pos] == v) return;
				if (store.size() >= MAXN) begin
					dropped = 1;
					return;
				end
				store.insert(pos, v);
				return;
			end
			if (store.size() == 0) begin
				if (tot_bytes == 0) begin
					r.off = '0; r.len = '0; r.last = 1; r.st = STAT_EMPTY;
					pending_ranges = {pending_ranges, r};
				end else if (chunk_bytes == 0) begin
					r.off = '0; r.len = tot_bytes; r.last = 1; r.st = STAT_OK;
					pending_ranges = {pending_ranges, r};
				end else begin
					chunks = (64'(tot_bytes) + 64'(chunk_bytes) - 1) / 64'(chunk_bytes);
					r.st = STAT_OK;
					if (chunks > MAXN) begin
						chunks = MAXN;
						r.st = STAT_TRUNC;
					end
					for (longint i = 0; i < chunks; i++) begin
						o = i * 64'(chunk_bytes);
						rem = 64'(tot_bytes) - o;
						r.off = o[SZ_W-1:0];
						r.len = SZ_W'((64'(chunk_bytes) < rem) ? 64'(chunk_bytes) : rem);
						r.last = (i == chunks - 1);
						pending_ranges = {pending_ranges, r};
					end
				end
			end else begin
				first = store[0];
				prev = first;
				for (int i = 1; i < store.size(); i++) begin
					if (64'(store[i]) != 64'(prev) + 64'd1) begin
						add_run(first, prev, 0);
						first = store[i];
					end
					prev = store[i];
				end
				add_run(first, prev, 1);
			end
			store.delete();
			dropped = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check(range_t got);
			range_t want;
			if (pending_ranges.size() == 0) begin
				report($sformatf("unexpected range off=%h len=%h", got.off, got.len));
				return;
			end
			want = pending_ranges.pop_front();
			if (got.off !== want.off)
				report($sformatf("offset %h, want %h", got.off, want.off));
			if (got.len !== want.len)
				report($sformatf("length %h, want %h", got.len, want.len));
			if (got.last !== want.last)
				report($sformatf("last_range %b, want %b", got.last, want.last));
			if (got.st !== want.st)
				report($sformatf("status %0d, want %0d", got.st, want.st));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_idx;
	logic [SZ_W-1:0] cfg_wdata;
	circ_req_if req();
	circ_rsp_if rsp();

	range_scoreboard sb;
	bit quiet;
	int items;
	longint cycles;

	chunk_index_range_coalescer_core #(.MAX_INDICES(MAXN)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("chunk_index_range_coalescer_core_tb NOT OK");
			$finish;
		end
	end

	always @(negedge clk)
		rsp.ready <= quiet || ($urandom_range(99) >= 22);

	always @(posedge clk)
		if (arst_n && rsp.valid && rsp.ready)
			sb.check({rsp.range_offset, rsp.range_length, rsp.last_range, rsp.status});

	task send(logic cmd, logic [IDX_W-1:0] v);
		@(negedge clk);
		if (!quiet && $urandom_range(99) < 22) begin
			req.valid <= 0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		req.valid <= 1;
		req.cmd <= cmd;
		req.chunk_index <= v;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sb.note(cmd, v);
		items++;
	endtask

	// hold the request side until every range has drained, then let the core go idle
	task drain();
		@(negedge clk);
		req.valid <= 0;
		while (sb.pending_ranges.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task write_cfg(cfg_idx_t idx, logic [SZ_W-1:0] val);
		drain();
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		sb.set_cfg(idx, val);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [CB_W-1:0] pick_chunk();
		case ($urandom_range(5))
			0: return 1;
			1: return '1;
			2: return $urandom_range(4096, 1);
			3: return $urandom() | 32'd1;
			default: return $urandom_range(64, 1);
		endcase
	endfunction

	function automatic logic [SZ_W-1:0] pick_total(logic [CB_W-1:0] cb);
		logic [63:0] t;
		case ($urandom_range(5))
			0: return 0;
			1: return SZ_MAX;
			2: return {$urandom(), $urandom()};
			default: begin
				t = 64'(cb) * $urandom_range(70) + 64'($urandom()) % 64'(cb);
				return t[SZ_W-1:0];
			end
		endcase
	endfunction

	initial begin
		logic [CB_W-1:0] cb;
		logic [IDX_W-1:0] base;
		int n;
		sb = new();
		quiet = 0;
		items = 0;
		cycles = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = CFG_CHUNK_BYTES;
		cfg_wdata = '0;
		req.valid = 0;
		req.cmd = CMD_LOAD;
		req.chunk_index = '0;
		rsp.ready = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// empty store at reset values: a single empty-status range
		send(CMD_EMIT, '1);
		write_cfg(CFG_CHUNK_BYTES, 4096);
		write_cfg(CFG_TOT_BYTES, 10000);
		send(CMD_EMIT, 0);
		send(CMD_LOAD, 0);
		send(CMD_LOAD, 1);
		send(CMD_LOAD, 2);
		send(CMD_LOAD, 2);
		send(CMD_LOAD, 5);
		send(CMD_LOAD, 1);
		send(CMD_EMIT, 0);
		// range starting exactly at the end
		write_cfg(CFG_TOT_BYTES, 8192);
		send(CMD_LOAD, 2);
		send(CMD_EMIT, 0);
		// split longer than the store: truncated
		write_cfg(CFG_CHUNK_BYTES, 1);
		write_cfg(CFG_TOT_BYTES, 100);
		send(CMD_EMIT, 0);
		write_cfg(CFG_CHUNK_BYTES, '1);
		write_cfg(CFG_TOT_BYTES, SZ_MAX);
		send(CMD_LOAD, '1);
		send(CMD_LOAD, 32'hFFFF_FFFE);
		send(CMD_LOAD, 0);
		send(CMD_LOAD, 1);
		send(CMD_EMIT, 0);
		send(CMD_EMIT, 0);

		while (items < 205) begin
			quiet = (items > 120 && items < 170);
			if ($urandom_range(2) == 0) begin
				cb = pick_chunk();
				write_cfg(CFG_CHUNK_BYTES, cb);
				write_cfg(CFG_TOT_BYTES, pick_total(cb));
			end
			if (items > 180 && items < 200)
				drain();
			case ($urandom_range(4))
				0: base = $urandom_range(40);
				1: base = 32'hFFFF_FFFF - $urandom_range(40);
				default: base = $urandom();
			endcase
			n = ($urandom_range(9) == 0) ? $urandom_range(72, 60) : $urandom_range(12);
			repeat (n) begin
				if ($urandom_range(9) == 0)
					send(CMD_LOAD, $urandom());
				else
					send(CMD_LOAD, base + $urandom_range(n + 4));
			end
			send(CMD_EMIT, $urandom());
		end

		drain();
		if (sb.errors == 0)
			$display("chunk_index_range_coalescer_core_tb OK");
		else
			$display("chunk_index_range_coalescer_core_tb NOT OK");
		$finish;
	end
endmodule
